[rtl/gic_pkg.sv]
// gic_pkg: types and constants for the gamepad input conditioner
// beat structs, sequencer states, register indexes, debounce and mapping constants
// no dependencies
package gic_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int HOLD_COUNT  = 3;
	localparam int NUM_LEVELS  = 11;
	localparam int CNT_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int QUO_BITS    = 8;

	localparam logic [CNT_W-1:0] CNT_MAX         = '1;
	localparam logic [CNT_W:0]   HOLD_LIMIT      = (CNT_W+1)'(HOLD_COUNT);
	localparam logic [7:0]       FRAME_FIXED_XOR = 8'h2A;
	localparam logic [7:0]       AXIS_CENTER     = 8'd127;
	localparam logic [7:0]       AXIS_FULL       = 8'd255;
	localparam logic [7:0]       AXIS_ZERO       = 8'd0;

	localparam logic [CFG_IDX_W-1:0] REG_X_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOW  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_X_INV  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Y_INV  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND   = 3'd6;

	typedef struct packed {
		logic [6:0]             main_buttons_raw;
		logic [1:0]             extra_buttons_raw;
		logic                   right_trigger_raw;
		logic                   left_trigger_raw;
		logic [SAMPLE_BITS-1:0] stick_x_sample;
		logic [SAMPLE_BITS-1:0] stick_y_sample;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] right_trigger_out;
		logic [7:0] left_trigger_out;
		logic [7:0] extra_buttons_byte;
		logic [7:0] main_buttons_byte;
		logic [7:0] stick_x_out;
		logic [7:0] stick_y_out;
		logic [7:0] frame_checksum;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD
	} seq_state_t;

endpackage

[rtl/gamepad_input_conditioner.sv]
// gamepad_input_conditioner: button debounce, stick dead-zone mapping, report checksum
// depends on gic_pkg; each stick axis uses a bit-serial restoring divider
//
// channel  | signals                                   | beat
// ---------+-------------------------------------------+---------------------------
// input    | in_valid, in_ready, in_data               | one poll (in_beat_t)
// output   | out_valid, out_ready, out_data            | one report (out_beat_t)
// config   | cfg_wr_en, cfg_idx, cfg_wdata             | one register write
//
// a poll's debounce and axis setup happen at the accepting edge, then the divider runs
// (one quotient bit per cycle) and a load step writes the output register.
// with the output register free, a new poll is taken once the sequencer is back in idle.
// arst_n clears all debounce state and loads the register reset values.
// in_ready is high only when the sequencer is idle; a finished result waits in the
// load step while the output register still holds an untaken beat.
module gamepad_input_conditioner
	import gic_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_beat_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_beat_t              out_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic [7:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic       x_inv_q, y_inv_q;
	logic [6:0] band_q;

	logic [CNT_W-1:0]      cnt_q [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] prev_q;
	logic [NUM_LEVELS-1:0] deb_q;

	logic [7:0] rem_q [2];
	logic [7:0] quo_q [2];
	logic [7:0] dvs_q [2];
	logic [1:0] fix_q;
	logic [7:0] fixval_q [2];
	logic [2:0] step_q;

	seq_state_t state_q, state_d;
	logic       accept, div_step, load_en;

	out_beat_t  out_q;
	logic       out_valid_q;

	// level vector in debounce order
	logic [NUM_LEVELS-1:0] lvl;
	logic [CNT_W-1:0]      cnt_d [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] deb_d;

	// axis setup
	logic [SAMPLE_BITS-1:0] smp [2];
	logic [7:0]  lo [2];
	logic [7:0]  hi [2];
	logic        inv [2];
	logic [7:0]  v [2];
	logic [7:0]  diff [2];
	logic [15:0] num [2];
	logic [1:0]  fix_d;
	logic [7:0]  fixval_d [2];

	// divider step
	logic [8:0]  trial [2];
	logic [8:0]  sub [2];
	logic [7:0]  rem_n [2];
	logic [7:0]  quo_n [2];

	out_beat_t  res;
	logic [7:0] sx, sy, rt, lt, eb, mb;

	assign accept = in_valid && in_ready;
	assign lvl = {in_data.left_trigger_raw, in_data.right_trigger_raw,
		in_data.extra_buttons_raw, in_data.main_buttons_raw};

	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			cnt_d[i] = cnt_q[i];
			deb_d[i] = deb_q[i];
			if (!lvl[i] && cnt_q[i] != CNT_MAX) begin
				cnt_d[i] = cnt_q[i] + 1'b1;
			end
			if (lvl[i] != prev_q[i]) begin
				cnt_d[i] = '0;
				deb_d[i] = 1'b0;
			end else if ({1'b0, cnt_d[i]} > HOLD_LIMIT) begin
				deb_d[i] = 1'b1;
			end
		end
	end

	always_comb begin
		smp[0] = in_data.stick_x_sample;
		smp[1] = in_data.stick_y_sample;
		lo[0]  = x_low_q;
		lo[1]  = y_low_q;
		hi[0]  = x_high_q;
		hi[1]  = y_high_q;
		inv[0] = x_inv_q;
		inv[1] = y_inv_q;
		for (int a = 0; a < 2; a++) begin
			v[a] = smp[a][SAMPLE_BITS-1 -: 8];
			if (inv[a]) begin
				v[a] = AXIS_FULL - v[a];
			end
			diff[a] = v[a] - lo[a];
			num[a] = {diff[a], 8'h00} - {8'h00, diff[a]};
			fix_d[a] = 1'b1;
			fixval_d[a] = AXIS_ZERO;
			if (v[a] < lo[a]) begin
				fixval_d[a] = AXIS_ZERO;
			end else if (v[a] > hi[a]) begin
				fixval_d[a] = AXIS_FULL;
			end else if ({1'b0, v[a]} < {1'b0, AXIS_CENTER} + {2'b00, band_q}
				&& {1'b0, v[a]} + {2'b00, band_q} > {1'b0, AXIS_CENTER}) begin
				fixval_d[a] = AXIS_CENTER;
			end else if (hi[a] == lo[a]) begin
				fixval_d[a] = AXIS_ZERO;
			end else begin
				fix_d[a] = 1'b0;
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			trial[a] = {rem_q[a], quo_q[a][7]};
			sub[a] = trial[a] - {1'b0, dvs_q[a]};
			if (trial[a] >= {1'b0, dvs_q[a]}) begin
				rem_n[a] = sub[a][7:0];
				quo_n[a] = {quo_q[a][6:0], 1'b1};
			end else begin
				rem_n[a] = trial[a][7:0];
				quo_n[a] = {quo_q[a][6:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= 8'd84;
			x_high_q <= 8'd164;
			y_low_q  <= 8'd84;
			y_high_q <= 8'd164;
			x_inv_q  <= 1'b0;
			y_inv_q  <= 1'b1;
			band_q   <= 7'd15;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_X_LOW:  x_low_q  <= cfg_wdata;
				REG_X_HIGH: x_high_q <= cfg_wdata;
				REG_Y_LOW:  y_low_q  <= cfg_wdata;
				REG_Y_HIGH: y_high_q <= cfg_wdata;
				REG_X_INV:  x_inv_q  <= cfg_wdata[0];
				REG_Y_INV:  y_inv_q  <= cfg_wdata[0];
				REG_BAND:   band_q   <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				cnt_q[i] <= '0;
			end
			prev_q <= '0;
			deb_q  <= '0;
		end else if (accept) begin
			cnt_q  <= cnt_d;
			prev_q <= lvl;
			deb_q  <= deb_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (div_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int a = 0; a < 2; a++) begin
				rem_q[a] <= num[a][15:8];
				quo_q[a] <= num[a][7:0];
				dvs_q[a] <= hi[a] - lo[a];
				fixval_q[a] <= fixval_d[a];
			end
			fix_q <= fix_d;
		end else if (div_step) begin
			for (int a = 0; a < 2; a++) begin
				rem_q[a] <= rem_n[a];
				quo_q[a] <= quo_n[a];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_DIV;
			ST_DIV:  if (step_q == 3'(QUO_BITS - 1)) state_d = ST_LOAD;
			ST_LOAD: if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		div_step = 1'b0;
		load_en  = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DIV:  div_step = 1'b1;
			ST_LOAD: load_en = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_comb begin
		sx = fix_q[0] ? fixval_q[0] : quo_q[0];
		sy = fix_q[1] ? fixval_q[1] : quo_q[1];
		rt = deb_q[9] ? AXIS_FULL : AXIS_ZERO;
		lt = deb_q[10] ? AXIS_FULL : AXIS_ZERO;
		eb = {5'b11111, ~deb_q[8], ~deb_q[7], 1'b1};
		mb = {~deb_q[6:0], 1'b1};
		res.right_trigger_out  = rt;
		res.left_trigger_out   = lt;
		res.extra_buttons_byte = eb;
		res.main_buttons_byte  = mb;
		res.stick_x_out        = sx;
		res.stick_y_out        = sy;
		res.frame_checksum     = FRAME_FIXED_XOR ^ rt ^ lt ^ eb ^ mb ^ sx ^ sy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[tb/gic_report_checker.sv]
`timescale 1ns / 1ps
// gic_report_checker: predicts one report beat per accepted poll and scores
// every report beat taken from the conditioner against the oldest prediction
// depends on gic_pkg; register writes are tracked from the write port
module gic_report_checker
	import gic_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_beat_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_beat_t             out_data,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    errors,
	output int                    pending
);

	typedef enum logic [1:0] {
		DB_RELEASE,
		DB_PRESS,
		DB_KEEP
	} db_evt_t;

	logic [CNT_W-1:0] hold_cnt [NUM_LEVELS];
	logic             prev_lvl [NUM_LEVELS];
	logic [7:0]       main_db;
	logic [7:0]       extra_db;
	logic [1:0]       trig_db;
	logic [7:0]       x_lo, x_hi, y_lo, y_hi;
	logic             x_inv, y_inv;
	logic [6:0]       band;
	out_beat_t        report_q [$];

	initial errors = 0;

	function automatic db_evt_t debounce_step(int idx, logic lvl);
		db_evt_t evt;
		evt = DB_KEEP;
		if (!lvl && hold_cnt[idx] != CNT_MAX)
			hold_cnt[idx] = hold_cnt[idx] + 1'b1;
		if (lvl != prev_lvl[idx]) begin
			hold_cnt[idx] = '0;
			evt = DB_RELEASE;
		end
		if (int'(hold_cnt[idx]) > HOLD_COUNT)
			evt = DB_PRESS;
		prev_lvl[idx] = lvl;
		return evt;
	endfunction

	function automatic logic [7:0] axis_map(logic [SAMPLE_BITS-1:0] s, logic [7:0] lo,
			logic [7:0] hi, logic inv);
		int v, l, h, b;
		v = int'(s[SAMPLE_BITS-1 -: 8]);
		l = int'(lo);
		h = int'(hi);
		b = int'(band);
		if (inv)
			v = 255 - v;
		if (v < l)
			return AXIS_ZERO;
		if (v > h)
			return AXIS_FULL;
		if (v < 127 + b && v + b > 127)
			return AXIS_CENTER;
		if (h == l)
			return AXIS_ZERO;
		return 8'(((v - l) * 255) / (h - l));
	endfunction

	function automatic out_beat_t predict_report(in_beat_t p);
		out_beat_t r;
		db_evt_t   evt;
		for (int i = 0; i < 7; i++) begin
			evt = debounce_step(i, p.main_buttons_raw[i]);
			if (evt == DB_RELEASE)
				main_db[i+1] = 1'b1;
			else if (evt == DB_PRESS)
				main_db[i+1] = 1'b0;
		end
		for (int i = 0; i < 2; i++) begin
			evt = debounce_step(7 + i, p.extra_buttons_raw[i]);
			if (evt == DB_RELEASE)
				extra_db[i+1] = 1'b1;
			else if (evt == DB_PRESS)
				extra_db[i+1] = 1'b0;
		end
		for (int i = 0; i < 2; i++) begin
			evt = debounce_step(9 + i, i == 0 ? p.right_trigger_raw : p.left_trigger_raw);
			if (evt == DB_RELEASE)
				trig_db[i] = 1'b0;
			else if (evt == DB_PRESS)
				trig_db[i] = 1'b1;
		end
		r.right_trigger_out  = trig_db[0] ? AXIS_FULL : AXIS_ZERO;
		r.left_trigger_out   = trig_db[1] ? AXIS_FULL : AXIS_ZERO;
		r.extra_buttons_byte = extra_db;
		r.main_buttons_byte  = main_db;
		r.stick_x_out        = axis_map(p.stick_x_sample, x_lo, x_hi, x_inv);
		r.stick_y_out        = axis_map(p.stick_y_sample, y_lo, y_hi, y_inv);
		r.frame_checksum     = FRAME_FIXED_XOR ^ r.right_trigger_out ^ r.left_trigger_out ^
			r.extra_buttons_byte ^ r.main_buttons_byte ^ r.stick_x_out ^ r.stick_y_out;
		return r;
	endfunction

	function automatic void check_field(string tag, logic [7:0] got, logic [7:0] want);
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("%0t report %s: expected %02h, got %02h", $time, tag, want, got);
		end
	endfunction

	function automatic void compare_report(out_beat_t got, out_beat_t want);
		check_field("right_trigger_out", got.right_trigger_out, want.right_trigger_out);
		check_field("left_trigger_out", got.left_trigger_out, want.left_trigger_out);
		check_field("extra_buttons_byte", got.extra_buttons_byte, want.extra_buttons_byte);
		check_field("main_buttons_byte", got.main_buttons_byte, want.main_buttons_byte);
		check_field("stick_x_out", got.stick_x_out, want.stick_x_out);
		check_field("stick_y_out", got.stick_y_out, want.stick_y_out);
		check_field("frame_checksum", got.frame_checksum, want.frame_checksum);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				hold_cnt[i] = '0;
				prev_lvl[i] = 1'b0;
			end
			main_db  = 8'hFF;
			extra_db = 8'hFF;
			trig_db  = 2'b00;
			x_lo     = 8'd84;
			x_hi     = 8'd164;
			y_lo     = 8'd84;
			y_hi     = 8'd164;
			x_inv    = 1'b0;
			y_inv    = 1'b1;
			band     = 7'd15;
			report_q.delete();
			pending <= 0;
		end else begin
			// results leave before new polls are queued: no poll completes in its own cycle
			if (out_valid && out_ready) begin
				if (report_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t report beat with nothing expected: %h", $time, out_data);
				end else begin
					compare_report(out_data, report_q.pop_front());
				end
			end
			if (in_valid && in_ready)
				report_q.push_back(predict_report(in_data));
			if (cfg_wr_en) begin
				case (cfg_idx)
					REG_X_LOW:  x_lo  = cfg_wdata;
					REG_X_HIGH: x_hi  = cfg_wdata;
					REG_Y_LOW:  y_lo  = cfg_wdata;
					REG_Y_HIGH: y_hi  = cfg_wdata;
					REG_X_INV:  x_inv = cfg_wdata[0];
					REG_Y_INV:  y_inv = cfg_wdata[0];
					REG_BAND:   band  = cfg_wdata[6:0];
					default: ;
				endcase
			end
			pending <= report_q.size();
		end
	end

endmodule

[tb/tb_gamepad_input_conditioner.sv]
`timescale 1ns / 1ps
// tb_gamepad_input_conditioner: drives polls and register settings into the
// conditioner under varying back-pressure; gic_report_checker scores the reports
// depends on gic_pkg, gamepad_input_conditioner and gic_report_checker
module tb_gamepad_input_conditioner;
	import gic_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_beat_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_beat_t             out_data;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    errors;
	int                    pending;

	int                    tx_idle_pct;
	int                    rx_idle_pct;
	int                    rx_hold_cycles;
	// button levels: [6:0] main, [8:7] extra, [9] right trigger, [10] left trigger
	logic [10:0]           lvl;
	logic [7:0]            cfg_shadow [7];
	logic [11:0]           dir_pts [16] = '{12'h000, 12'hFFF, 12'h7F0, 12'h540, 12'h530,
		12'h550, 12'hA40, 12'hA50, 12'h710, 12'h700, 12'h8E0, 12'h8F0, 12'h80F,
		12'h7FF, 12'hA4F, 12'h00F};

	gamepad_input_conditioner u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	gic_report_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_gamepad_input_conditioner: done, errors");
		$finish;
	end

	// report side: random ready, or a long counted hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic in_beat_t make_poll(logic [11:0] sx, logic [11:0] sy);
		in_beat_t p;
		p.main_buttons_raw  = lvl[6:0];
		p.extra_buttons_raw = lvl[8:7];
		p.right_trigger_raw = lvl[9];
		p.left_trigger_raw  = lvl[10];
		p.stick_x_sample    = sx;
		p.stick_y_sample    = sy;
		return p;
	endfunction

	// half the time near the clamp and dead-zone edges of the current setting, else random
	function automatic logic [11:0] stick_sample(logic [7:0] lo, logic [7:0] hi, logic inv);
		int v, b;
		b = int'(cfg_shadow[REG_BAND][6:0]);
		case ($urandom_range(7))
			0: v = int'(lo) + int'($urandom_range(2)) - 1;
			1: v = int'(hi) + int'($urandom_range(2)) - 1;
			2: v = 127 - b + int'($urandom_range(2)) - 1;
			3: v = 127 + b + int'($urandom_range(2)) - 1;
			4: v = int'($urandom_range(255));
			default: return 12'($urandom);
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		if (inv)
			v = 255 - v;
		return {v[7:0], 4'($urandom)};
	endfunction

	// levels mostly held so that presses get through, with single changes and noise
	function automatic in_beat_t random_poll();
		int roll;
		int flip;
		roll = $urandom_range(99);
		flip = $urandom_range(10);
		if (roll < 10)
			lvl = 11'($urandom);
		else if (roll < 35)
			lvl[flip] = ~lvl[flip];
		return make_poll(stick_sample(cfg_shadow[REG_X_LOW], cfg_shadow[REG_X_HIGH],
				cfg_shadow[REG_X_INV][0]),
			stick_sample(cfg_shadow[REG_Y_LOW], cfg_shadow[REG_Y_HIGH],
				cfg_shadow[REG_Y_INV][0]));
	endfunction

	task automatic send_poll(input in_beat_t p);
		int gap;
		gap = 0;
		if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic load_config();
		write_reg(REG_X_LOW, cfg_shadow[REG_X_LOW]);
		write_reg(REG_X_HIGH, cfg_shadow[REG_X_HIGH]);
		write_reg(REG_Y_LOW, cfg_shadow[REG_Y_LOW]);
		write_reg(REG_Y_HIGH, cfg_shadow[REG_Y_HIGH]);
		write_reg(REG_X_INV, cfg_shadow[REG_X_INV]);
		write_reg(REG_Y_INV, cfg_shadow[REG_Y_INV]);
		write_reg(REG_BAND, cfg_shadow[REG_BAND]);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(input int n, input int hold_at, input int pause_at);
		for (int k = 0; k < n; k++) begin
			if (k == hold_at)
				rx_hold_cycles = 150;
			if (k == pause_at)
				drain();
			send_poll(random_poll());
		end
	endtask

	initial begin
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_wr_en      = 1'b0;
		cfg_idx        = '0;
		cfg_wdata      = '0;
		tx_idle_pct    = 20;
		rx_idle_pct    = 65;
		rx_hold_cycles = 0;
		lvl            = '1;
		cfg_shadow     = '{8'd84, 8'd164, 8'd84, 8'd164, 8'd0, 8'd1, 8'd15};
		arst_n         = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// release from reset, full hold into saturation, chatter, one long press
		for (int k = 0; k < 20; k++) begin
			if (k == 0)
				lvl = '1;
			else if (k <= 9)
				lvl = '0;
			else if (k <= 13)
				lvl = k[0] ? 11'h555 : 11'h2AA;
			else
				lvl = 11'h7FE;
			send_poll(make_poll(dir_pts[k % 16], dir_pts[(k + 5) % 16]));
		end
		run_random(100, -1, -1);
		drain();

		// full-range x, equal y limits, no dead zone
		cfg_shadow = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0};
		load_config();
		run_random(100, -1, -1);
		drain();

		tx_idle_pct = 65;
		rx_idle_pct = 20;
		// low above high, zero-width y range, widest dead zone
		cfg_shadow = '{8'd200, 8'd50, 8'd0, 8'd0, 8'd1, 8'd1, 8'd127};
		load_config();
		run_random(100, -1, 50);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		cfg_shadow[REG_X_LOW]  = 8'($urandom_range(200));
		cfg_shadow[REG_X_HIGH] = cfg_shadow[REG_X_LOW] + 8'($urandom_range(1, 55));
		cfg_shadow[REG_Y_LOW]  = 8'($urandom_range(200));
		cfg_shadow[REG_Y_HIGH] = cfg_shadow[REG_Y_LOW] + 8'($urandom_range(1, 55));
		cfg_shadow[REG_X_INV]  = 8'($urandom_range(1));
		cfg_shadow[REG_Y_INV]  = 8'($urandom_range(1));
		cfg_shadow[REG_BAND]   = 8'($urandom_range(127));
		load_config();
		run_random(100, 20, -1);
		drain();

		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_gamepad_input_conditioner: done, clean");
		else
			$display("tb_gamepad_input_conditioner: done, errors");
		$finish;
	end

endmodule

[sim.f]
rtl/gic_pkg.sv
rtl/gamepad_input_conditioner.sv
tb/gic_report_checker.sv
tb/tb_gamepad_input_conditioner.sv
